// ----- hw/rtl/cfsv_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Circle fan strip package
// Shared widths, angle constants, command and status types, and the
// per-degree sine magnitude table in unsigned Q1.16 form.
// ----------------------------------------------------------------------------
package cfsv_pkg;

    localparam int ANGLE_STEP_DEGREES = 6;
    localparam int TRIG_FRACTION_BITS = 16;

    localparam int COORD_W  = 32;
    localparam int RADIUS_W = 31;
    localparam int ARC_W    = 9;
    localparam int ANGLE_W  = 10;
    localparam int DEG_W    = 7;
    localparam int MAG_W    = TRIG_FRACTION_BITS + 1;
    localparam int PROD_W   = RADIUS_W + MAG_W;
    localparam int COUNT_W  = 6;
    localparam int STRIP_W  = COUNT_W + 1;
    localparam int TABLE_N  = 91;

    localparam logic [ANGLE_W-1:0] ANGLE_STEP   = ANGLE_W'(ANGLE_STEP_DEGREES);
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = ANGLE_W'(90);
    localparam logic [ANGLE_W-1:0] HALF_TURN    = ANGLE_W'(180);
    localparam logic [ANGLE_W-1:0] THREE_QUARTER_TURN = ANGLE_W'(270);
    localparam logic [ANGLE_W-1:0] FULL_TURN    = ANGLE_W'(360);
    localparam logic [ANGLE_W-1:0] PARTIAL_END  = ANGLE_W'(450);
    localparam logic [ARC_W-1:0]   ARC_MAX      = ARC_W'(360);

    localparam longint unsigned TABLE_SCALE = 64'd10000000;
    localparam longint unsigned TABLE_HALF  = TABLE_SCALE / 2;

    localparam int unsigned SIN_RAW [TABLE_N] = '{
        0, 174524, 348995, 523360, 697565, 871557, 1045285, 1218693,
        1391731, 1564345, 1736482, 1908090, 2079117, 2249511, 2419219,
        2588190, 2756374, 2923717, 3090170, 3255682, 3420201, 3583679,
        3746066, 3907311, 4067366, 4226183, 4383711, 4539905, 4694716,
        4848096, 5000000, 5150381, 5299193, 5446390, 5591929, 5735764,
        5877853, 6018150, 6156615, 6293204, 6427876, 6560590, 6691306,
        6819984, 6946584, 7071068, 7193398, 7313537, 7431448, 7547096,
        7660444, 7771460, 7880108, 7986355, 8090170, 8191520, 8290376,
        8386706, 8480481, 8571673, 8660254, 8746197, 8829476, 8910065,
        8987940, 9063078, 9135455, 9205049, 9271839, 9335804, 9396926,
        9455186, 9510565, 9563048, 9612617, 9659258, 9702957, 9743701,
        9781476, 9816272, 9848078, 9876883, 9902681, 9925462, 9945219,
        9961947, 9975641, 9986295, 9993908, 9998477, 10000000
    };

    typedef logic [MAG_W-1:0] mag_table_t [TABLE_N];

    function automatic mag_table_t build_mag_table();
        mag_table_t      t;
        longint unsigned e;
        for (int d = 0; d < TABLE_N; d++)
        begin
            e    = 64'(SIN_RAW[d]);
            t[d] = MAG_W'((e * (64'd1 << TRIG_FRACTION_BITS) + TABLE_HALF) / TABLE_SCALE);
        end
        return t;
    endfunction

    localparam mag_table_t MAG_TABLE = build_mag_table();

    typedef struct packed {
        logic               load;
        logic               issue;
        logic [ANGLE_W-1:0] angle;
        logic               last;
        logic [STRIP_W-1:0] strip;
    } cfsv_cmd_t;

    typedef struct packed {
        logic advance;
    } cfsv_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/circle_fan_strip_vertex_generator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Circle fan strip vertex generator
// Throughput: one request beat, then one pair per cycle from the angle
// sequencer while m_axis_tready does not stall the output; a new request
// is taken once the last angle of the previous one has been issued to the
// four-stage pipeline.
// Reset: rst_n clears the controller state and the pipeline valid bits.
// ----------------------------------------------------------------------------
// Top level: streaming ports around the controller and the datapath.
// ----------------------------------------------------------------------------
module circle_fan_strip_vertex_generator
    import cfsv_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // center_x[31:0], center_y[63:32], radius[94:64], arc_degrees[103:95]
    input  wire logic [103:0] s_axis_tdata,
    // func[0]
    input  wire logic [0:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // rim_x[31:0], rim_y[63:32], hub_x[95:64], hub_y[127:96],
    // strip_points[134:128], zero[135]
    output logic [135:0]      m_axis_tdata,
    output logic              m_axis_tlast
);

    cfsv_cmd_t                 cmd;
    cfsv_status_t              status;
    logic signed [COORD_W-1:0] rim_x, rim_y, hub_x, hub_y;
    logic [STRIP_W-1:0]        strip_points;

    cfsv_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req_func  (s_axis_tuser[0]),
        .req_arc   (s_axis_tdata[103:95]),
        .status    (status),
        .cmd       (cmd)
    );

    cfsv_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .req_center_x ($signed(s_axis_tdata[31:0])),
        .req_center_y ($signed(s_axis_tdata[63:32])),
        .req_radius   (s_axis_tdata[94:64]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .rim_x        (rim_x),
        .rim_y        (rim_y),
        .hub_x        (hub_x),
        .hub_y        (hub_y),
        .last         (m_axis_tlast),
        .strip_points (strip_points)
    );

    assign m_axis_tdata = {1'b0, strip_points, hub_y, hub_x, rim_y, rim_x};

endmodule
`default_nettype wire

// ----- hw/rtl/cfsv_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Circle fan strip controller
// Accepts a request, then walks the angle sequence and issues one angle
// per advancing cycle to the datapath, flagging the final pair.
// ----------------------------------------------------------------------------
module cfsv_ctrl
    import cfsv_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire logic               req_func,
    input  wire logic [ARC_W-1:0]   req_arc,
    input  wire cfsv_status_t       status,
    output cfsv_cmd_t               cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [ANGLE_W-1:0]   angle_reg, angle_next;
    logic [ANGLE_W-1:0]   end_reg, end_next;
    logic                 full_reg, full_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    logic                 accept;
    logic                 issue;
    logic                 last_pair;
    logic [ANGLE_W-1:0]   step_sum;
    logic [ARC_W-1:0]     arc_sat;
    logic [COUNT_W-1:0]   count_plus;

    assign req_ready  = (state_reg == ST_IDLE);
    assign accept     = req_valid && req_ready;
    assign issue      = (state_reg == ST_RUN) && status.advance;
    assign step_sum   = angle_reg + ANGLE_STEP;
    assign arc_sat    = (req_arc > ARC_MAX) ? ARC_MAX : req_arc;
    assign count_plus = count_reg + COUNT_W'(1);
    assign last_pair  = full_reg ? (step_sum > FULL_TURN) : (angle_reg == end_reg);

    always_comb
    begin
        state_next = state_reg;
        angle_next = angle_reg;
        end_next   = end_reg;
        full_next  = full_reg;
        count_next = count_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    full_next  = !req_func;
                    angle_next = req_func ? QUARTER_TURN : '0;
                    end_next   = PARTIAL_END - {{(ANGLE_W-ARC_W){1'b0}}, arc_sat};
                    count_next = '0;
                end
            end
            ST_RUN:
            begin
                if (issue)
                begin
                    count_next = count_plus;
                    if (last_pair)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (!full_reg && (step_sum >= end_reg))
                    begin
                        angle_next = end_reg;
                    end
                    else
                    begin
                        angle_next = step_sum;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            angle_reg <= '0;
            end_reg   <= '0;
            full_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            angle_reg <= angle_next;
            end_reg   <= end_next;
            full_reg  <= full_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        cmd.load  = accept;
        cmd.issue = issue;
        cmd.angle = angle_reg;
        cmd.last  = last_pair;
        cmd.strip = last_pair ? {count_plus, 1'b0} : '0;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/cfsv_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Circle fan strip datapath
// Four-stage pipeline: angle folding, table lookup, radius multiply, then
// rounding, sign and center add into the output register. All stages stall
// together while the output beat is held.
// ----------------------------------------------------------------------------
module cfsv_datapath
    import cfsv_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cfsv_cmd_t                 cmd,
    output cfsv_status_t                   status,
    input  wire logic signed [COORD_W-1:0] req_center_x,
    input  wire logic signed [COORD_W-1:0] req_center_y,
    input  wire logic [RADIUS_W-1:0]       req_radius,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic signed [COORD_W-1:0]      rim_x,
    output logic signed [COORD_W-1:0]      rim_y,
    output logic signed [COORD_W-1:0]      hub_x,
    output logic signed [COORD_W-1:0]      hub_y,
    output logic                           last,
    output logic [STRIP_W-1:0]             strip_points
);

    typedef struct packed {
        logic [DEG_W-1:0] idx;
        logic             neg;
    } fold_t;

    function automatic fold_t fold_angle(logic [ANGLE_W-1:0] a);
        fold_t f;
        if (a <= QUARTER_TURN)
        begin
            f.idx = DEG_W'(a);
            f.neg = 1'b0;
        end
        else if (a <= HALF_TURN)
        begin
            f.idx = DEG_W'(HALF_TURN - a);
            f.neg = 1'b0;
        end
        else if (a <= THREE_QUARTER_TURN)
        begin
            f.idx = DEG_W'(a - HALF_TURN);
            f.neg = 1'b1;
        end
        else
        begin
            f.idx = DEG_W'(FULL_TURN - a);
            f.neg = 1'b1;
        end
        return f;
    endfunction

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (TRIG_FRACTION_BITS - 1);

    logic                        advance;

    logic signed [COORD_W-1:0]   cx_req_reg, cy_req_reg;
    logic [RADIUS_W-1:0]         r_req_reg;

    logic                        v1_reg, v2_reg, v3_reg, v4_reg;

    fold_t                       sin1_reg, cos1_reg;
    logic signed [COORD_W-1:0]   cx1_reg, cy1_reg, cx2_reg, cy2_reg, cx3_reg, cy3_reg;
    logic [RADIUS_W-1:0]         r1_reg, r2_reg;
    logic                        last1_reg, last2_reg, last3_reg;
    logic [STRIP_W-1:0]          strip1_reg, strip2_reg, strip3_reg;

    logic [MAG_W-1:0]            smag2_reg, cmag2_reg;
    logic                        sneg2_reg, cneg2_reg, sneg3_reg, cneg3_reg;
    logic [PROD_W-1:0]           prod_x3_reg, prod_y3_reg;

    logic signed [COORD_W-1:0]   rim_x_reg, rim_y_reg, hub_x_reg, hub_y_reg;
    logic                        last4_reg;
    logic [STRIP_W-1:0]          strip4_reg;

    logic [ANGLE_W-1:0]          a_mod;
    logic [ANGLE_W-1:0]          c_sum;
    logic [ANGLE_W-1:0]          c_mod;
    logic [PROD_W-1:0]           round_x, round_y;
    logic [COORD_W-1:0]          mag_x, mag_y, off_x, off_y;

    assign advance        = !v4_reg || out_ready;
    assign status.advance = advance;

    assign a_mod = (cmd.angle >= FULL_TURN) ? (cmd.angle - FULL_TURN) : cmd.angle;
    assign c_sum = a_mod + QUARTER_TURN;
    assign c_mod = (c_sum >= FULL_TURN) ? (c_sum - FULL_TURN) : c_sum;

    assign round_x = prod_x3_reg + ROUND_HALF;
    assign round_y = prod_y3_reg + ROUND_HALF;
    assign mag_x   = COORD_W'(round_x >> TRIG_FRACTION_BITS);
    assign mag_y   = COORD_W'(round_y >> TRIG_FRACTION_BITS);
    assign off_x   = cneg3_reg ? (COORD_W'(0) - mag_x) : mag_x;
    assign off_y   = sneg3_reg ? (COORD_W'(0) - mag_y) : mag_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_req_reg <= req_center_x;
            cy_req_reg <= req_center_y;
            r_req_reg  <= req_radius;
        end
        if (advance)
        begin
            sin1_reg   <= fold_angle(a_mod);
            cos1_reg   <= fold_angle(c_mod);
            cx1_reg    <= cx_req_reg;
            cy1_reg    <= cy_req_reg;
            r1_reg     <= r_req_reg;
            last1_reg  <= cmd.last;
            strip1_reg <= cmd.strip;

            smag2_reg  <= MAG_TABLE[sin1_reg.idx];
            cmag2_reg  <= MAG_TABLE[cos1_reg.idx];
            sneg2_reg  <= sin1_reg.neg;
            cneg2_reg  <= cos1_reg.neg;
            cx2_reg    <= cx1_reg;
            cy2_reg    <= cy1_reg;
            r2_reg     <= r1_reg;
            last2_reg  <= last1_reg;
            strip2_reg <= strip1_reg;

            prod_x3_reg <= PROD_W'(r2_reg) * PROD_W'(cmag2_reg);
            prod_y3_reg <= PROD_W'(r2_reg) * PROD_W'(smag2_reg);
            sneg3_reg   <= sneg2_reg;
            cneg3_reg   <= cneg2_reg;
            cx3_reg     <= cx2_reg;
            cy3_reg     <= cy2_reg;
            last3_reg   <= last2_reg;
            strip3_reg  <= strip2_reg;

            rim_x_reg  <= cx3_reg + $signed(off_x);
            rim_y_reg  <= cy3_reg + $signed(off_y);
            hub_x_reg  <= cx3_reg;
            hub_y_reg  <= cy3_reg;
            last4_reg  <= last3_reg;
            strip4_reg <= strip3_reg;
        end
    end

    assign out_valid    = v4_reg;
    assign rim_x        = rim_x_reg;
    assign rim_y        = rim_y_reg;
    assign hub_x        = hub_x_reg;
    assign hub_y        = hub_y_reg;
    assign last         = last4_reg;
    assign strip_points = strip4_reg;

endmodule
`default_nettype wire
